[rtl/soa_pkg.sv]
// Shared types and codes for the slab object allocator.
// No dependencies; every other file imports it.
package soa_pkg;

	localparam int HANDLE_W    = 10;
	localparam int NUM_SLABS   = 16;
	localparam int MAX_OBJECTS = 64;

	typedef enum logic [1:0] {
		TAG_NONE    = 2'd0,
		TAG_PARTIAL = 2'd1,
		TAG_FULL    = 2'd2,
		TAG_EMPTY   = 2'd3
	} tag_t;

	typedef enum logic [1:0] {
		ST_ALLOC   = 2'd0,
		ST_FREED   = 2'd1,
		ST_NO_PAGE = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef struct packed {
		logic                op;
		logic [HANDLE_W-1:0] obj_handle;
	} req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [HANDLE_W-1:0] granted_handle;
		logic [6:0]          slab_in_use;
		logic [10:0]         live_objects;
		logic [4:0]          live_slabs;
	} rsp_t;

	localparam logic [6:0] CFG_RESET = 7'd32;

endpackage

[rtl/soa_apb_regs.sv]
// APB register block holding the per-slab object count.
// Depends on soa_pkg.
module soa_apb_regs import soa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [6:0]  slab_capacity
);

	logic [6:0] cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (psel && penable && pwrite && paddr == 3'd0) begin
			cfg_q <= pwdata[6:0];
		end
	end

	assign pready        = 1'b1;
	assign prdata        = (paddr == 3'd0) ? {25'd0, cfg_q} : 32'd0;
	assign slab_capacity = cfg_q;

endmodule

[rtl/soa_ctrl.sv]
// Request sequencer with slab record memory and object link memory.
// Depends on soa_pkg.
module soa_ctrl import soa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [6:0] slab_capacity,
	input  logic       start,
	output logic       busy,
	input  req_t       req,
	output logic       done,
	output rsp_t       rsp
);

	localparam int SW  = $clog2(NUM_SLABS + 1);
	localparam int SIW = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
	localparam int OW  = $clog2(MAX_OBJECTS + 1);
	localparam int OSH = $clog2(MAX_OBJECTS);
	localparam int AW  = (NUM_SLABS * MAX_OBJECTS > 1) ? $clog2(NUM_SLABS * MAX_OBJECTS) : 1;
	localparam logic [SW-1:0] SNULL = SW'(NUM_SLABS);
	localparam logic [OW-1:0] ONULL = OW'(MAX_OBJECTS);
	localparam logic [AW-1:0] MAXA  = AW'(MAX_OBJECTS);

	typedef struct packed {
		logic [SW-1:0] nxt;
		logic [SW-1:0] prv;
		logic [6:0]    used;
		logic [OW-1:0] chain;
	} rec_t;

	typedef enum logic [13:0] {
		S_IDLE  = 14'h0001,
		S_DEC   = 14'h0002,
		S_RD    = 14'h0004,
		S_LD    = 14'h0008,
		S_INIT  = 14'h0010,
		S_POP   = 14'h0020,
		S_POP2  = 14'h0040,
		S_UL_P  = 14'h0080,
		S_UL_PW = 14'h0100,
		S_UL_N  = 14'h0200,
		S_UL_NW = 14'h0400,
		S_PS    = 14'h0800,
		S_PS_W  = 14'h1000,
		S_RESP  = 14'h2000
	} state_t;

	rec_t                rec_mem [NUM_SLABS];
	logic [OW-1:0]       obj_mem [NUM_SLABS * MAX_OBJECTS];

	state_t              state_q, cont_q;
	tag_t                tag_q [NUM_SLABS];
	logic [SW-1:0]       head_q [3];
	logic [SW-1:0]       pages_q, live_slab_q;
	logic [10:0]         live_obj_q;
	logic [SIW-1:0]      s_q;
	logic [OW-1:0]       o_q;
	logic                op_q, reuse_q, dirty_q;
	logic [HANDLE_W-1:0] h_q;
	logic [6:0]          init_q;
	tag_t                newtag_q;
	status_t             status_q;
	rec_t                rec_q, rec_rd;
	logic [OW-1:0]       obj_rd;
	logic                done_q;
	rsp_t                rsp_q;

	logic [6:0]          n_eff;
	logic [SIW-1:0]      rec_ra, rec_wa;
	logic                rec_we, obj_we;
	rec_t                rec_wd, rec_freed;
	logic [AW-1:0]       obj_ra, obj_wa, s_base;
	logic [OW-1:0]       obj_wd;
	logic [HANDLE_W-1:0] quo, rem;
	logic [6:0]          used_inc, used_dec;
	tag_t                cur_tag;

	function automatic logic [1:0] hsel(input tag_t t);
		case (t)
			TAG_FULL:  hsel = 2'd1;
			TAG_EMPTY: hsel = 2'd2;
			default:   hsel = 2'd0;
		endcase
	endfunction

	function automatic logic sval(input logic [SW-1:0] v);
		sval = ({1'b0, v} < (SW + 1)'(NUM_SLABS));
	endfunction

	assign n_eff = (slab_capacity == 7'd0) ? 7'd1 :
		(({2'b0, slab_capacity} > 9'(MAX_OBJECTS)) ? 7'(MAX_OBJECTS) : slab_capacity);
	assign s_base   = AW'(s_q) * MAXA;
	assign quo      = h_q >> OSH;
	assign rem      = h_q & HANDLE_W'(MAX_OBJECTS - 1);
	assign used_inc = (rec_q.used != 7'h7F) ? rec_q.used + 7'd1 : rec_q.used;
	assign used_dec = (rec_rd.used != 7'd0) ? rec_rd.used - 7'd1 : rec_rd.used;
	assign cur_tag  = tag_q[s_q];
	assign rec_freed = '{nxt: rec_rd.nxt, prv: rec_rd.prv, used: used_dec, chain: o_q};

	always_comb begin
		rec_ra = s_q;
		rec_we = 1'b0;
		rec_wa = s_q;
		rec_wd = rec_q;
		obj_we = 1'b0;
		obj_wa = s_base + AW'(o_q);
		obj_wd = rec_rd.chain;
		obj_ra = s_base + AW'(rec_q.chain);
		case (state_q)
			S_UL_P: rec_ra = SIW'(rec_q.prv);
			S_UL_N: rec_ra = SIW'(rec_q.nxt);
			S_PS:   rec_ra = SIW'(head_q[hsel(newtag_q)]);
			S_UL_PW: begin
				rec_we     = 1'b1;
				rec_wa     = SIW'(rec_q.prv);
				rec_wd     = rec_rd;
				rec_wd.nxt = rec_q.nxt;
			end
			S_UL_NW: begin
				rec_we     = 1'b1;
				rec_wa     = SIW'(rec_q.nxt);
				rec_wd     = rec_rd;
				rec_wd.prv = rec_q.prv;
			end
			S_PS_W: begin
				rec_we     = 1'b1;
				rec_wa     = SIW'(head_q[hsel(newtag_q)]);
				rec_wd     = rec_rd;
				rec_wd.prv = SW'(s_q);
			end
			S_RESP: rec_we = dirty_q;
			S_LD:   obj_we = (op_q == OP_FREE);
			S_INIT: begin
				obj_we = 1'b1;
				obj_wa = s_base + AW'(init_q);
				obj_wd = ({1'b0, init_q} + 8'd1 < {1'b0, n_eff}) ?
					OW'({1'b0, init_q} + 8'd1) : ONULL;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rec_we) rec_mem[rec_wa] <= rec_wd;
		rec_rd <= rec_mem[rec_ra];
		if (obj_we) obj_mem[obj_wa] <= obj_wd;
		obj_rd <= obj_mem[obj_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cont_q      <= S_IDLE;
			for (int i = 0; i < NUM_SLABS; i++) tag_q[i] <= TAG_NONE;
			for (int i = 0; i < 3; i++) head_q[i] <= SNULL;
			pages_q     <= '0;
			live_slab_q <= '0;
			live_obj_q  <= '0;
			done_q      <= 1'b0;
			dirty_q     <= 1'b0;
			reuse_q     <= 1'b0;
		end else begin
			done_q <= (state_q == S_RESP);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q    <= req.op;
						h_q     <= req.obj_handle;
						dirty_q <= 1'b0;
						reuse_q <= 1'b0;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (op_q == OP_FREE) begin
						s_q <= SIW'(quo);
						o_q <= OW'(rem);
						if ((quo >= HANDLE_W'(NUM_SLABS)) || (rem >= HANDLE_W'(n_eff)) ||
							(tag_q[SIW'(quo)] != TAG_PARTIAL &&
							tag_q[SIW'(quo)] != TAG_FULL)) begin
							status_q <= ST_IGNORED;
							state_q  <= S_RESP;
						end else begin
							state_q <= S_RD;
						end
					end else if (sval(head_q[0])) begin
						s_q     <= SIW'(head_q[0]);
						state_q <= S_RD;
					end else if (sval(head_q[2])) begin
						s_q         <= SIW'(head_q[2]);
						reuse_q     <= 1'b1;
						live_slab_q <= live_slab_q + SW'(1);
						state_q     <= S_RD;
					end else if (sval(pages_q)) begin
						s_q         <= SIW'(pages_q);
						pages_q     <= pages_q + SW'(1);
						live_slab_q <= live_slab_q + SW'(1);
						init_q      <= '0;
						state_q     <= S_INIT;
					end else begin
						status_q <= ST_NO_PAGE;
						state_q  <= S_RESP;
					end
				end
				S_RD: state_q <= S_LD;
				S_LD: begin
					dirty_q <= 1'b1;
					if (op_q == OP_FREE) begin
						rec_q    <= rec_freed;
						status_q <= ST_FREED;
						if (live_obj_q != 11'd0) live_obj_q <= live_obj_q - 11'd1;
						cont_q <= S_RESP;
						if (used_dec == 7'd0) begin
							newtag_q <= TAG_EMPTY;
							if (live_slab_q != '0) live_slab_q <= live_slab_q - SW'(1);
							state_q <= S_UL_P;
						end else if (cur_tag == TAG_FULL) begin
							newtag_q <= TAG_PARTIAL;
							state_q  <= S_UL_P;
						end else begin
							state_q <= S_RESP;
						end
					end else if (reuse_q) begin
						rec_q    <= rec_rd;
						newtag_q <= TAG_PARTIAL;
						cont_q   <= S_POP;
						state_q  <= S_UL_P;
					end else begin
						rec_q   <= rec_rd;
						state_q <= S_POP;
					end
				end
				S_INIT: begin
					init_q <= init_q + 7'd1;
					if ({1'b0, init_q} + 8'd1 >= {1'b0, n_eff}) begin
						rec_q.chain <= '0;
						rec_q.used  <= '0;
						dirty_q     <= 1'b1;
						newtag_q    <= TAG_PARTIAL;
						cont_q      <= S_POP;
						state_q     <= S_PS;
					end
				end
				S_POP: begin
					if ({1'b0, rec_q.chain} >= (OW + 1)'(MAX_OBJECTS)) begin
						status_q <= ST_NO_PAGE;
						newtag_q <= TAG_FULL;
						cont_q   <= S_RESP;
						state_q  <= S_UL_P;
					end else begin
						o_q     <= rec_q.chain;
						state_q <= S_POP2;
					end
				end
				S_POP2: begin
					rec_q.chain <= obj_rd;
					rec_q.used  <= used_inc;
					live_obj_q  <= live_obj_q + 11'd1;
					status_q    <= ST_ALLOC;
					if (used_inc >= n_eff || {1'b0, obj_rd} >= (OW + 1)'(MAX_OBJECTS)) begin
						newtag_q <= TAG_FULL;
						cont_q   <= S_RESP;
						state_q  <= S_UL_P;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_UL_P: begin
					if (cur_tag == TAG_NONE) begin
						state_q <= S_PS;
					end else if (sval(rec_q.prv)) begin
						state_q <= S_UL_PW;
					end else begin
						head_q[hsel(cur_tag)] <= sval(rec_q.nxt) ? rec_q.nxt : SNULL;
						state_q <= S_UL_N;
					end
				end
				S_UL_PW: state_q <= S_UL_N;
				S_UL_N: begin
					if (!sval(rec_q.prv)) rec_q.prv <= SNULL;
					state_q <= sval(rec_q.nxt) ? S_UL_NW : S_PS;
				end
				S_UL_NW: state_q <= S_PS;
				S_PS: begin
					rec_q.nxt <= sval(head_q[hsel(newtag_q)]) ? head_q[hsel(newtag_q)] : SNULL;
					rec_q.prv <= SNULL;
					if (sval(head_q[hsel(newtag_q)])) begin
						state_q <= S_PS_W;
					end else begin
						head_q[hsel(newtag_q)] <= SW'(s_q);
						tag_q[s_q] <= newtag_q;
						state_q    <= cont_q;
					end
				end
				S_PS_W: begin
					head_q[hsel(newtag_q)] <= SW'(s_q);
					tag_q[s_q] <= newtag_q;
					state_q    <= cont_q;
				end
				S_RESP: begin
					rsp_q.status          <= status_q;
					rsp_q.granted_handle  <= (status_q == ST_ALLOC) ?
						HANDLE_W'(s_base + AW'(o_q)) : '0;
					rsp_q.slab_in_use     <= (status_q == ST_ALLOC || status_q == ST_FREED) ?
						rec_q.used : 7'd0;
					rsp_q.live_objects    <= live_obj_q;
					rsp_q.live_slabs      <= 5'(live_slab_q);
					state_q               <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

[rtl/slab_object_allocator.sv]
// Slab object allocator: an alloc is served from a partial slab, a reused empty slab or a fresh
// page whose object links are written first, else it reports no page left; a free or an ignored
// free ends in a response, and a tag change adds a list move. One request at a time, as start
// is taken only while the sequencer is idle; the next start is taken in the done cycle.
// The result beat is one cycle on done; the receiver cannot stall. Reset clears list
// heads, tags and counters at once; the memories are left unwritten.
module slab_object_allocator import soa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  req_t        req,
	output logic        done,
	output rsp_t        rsp
);

	logic [6:0] slab_capacity;

	soa_apb_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.slab_capacity (slab_capacity)
	);

	soa_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.slab_capacity (slab_capacity),
		.start         (start),
		.busy          (busy),
		.req           (req),
		.done          (done),
		.rsp           (rsp)
	);

endmodule
